>>> hdl/gsfp_pkg.sv
// ----------------------------------------------------------------------------
// Gas sensor frame parser package
// Shared constants, register indexes, the frame record that passes from the
// frame tracker to the level evaluation stage, and the result record.
// ----------------------------------------------------------------------------
package gsfp_pkg;

  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned POS_W       = 4;
  localparam int unsigned CONC_W      = 13;
  localparam int unsigned SCALED_W    = 15;
  localparam int unsigned CFG_DATA_W  = 15;

  localparam logic [BYTE_W-1:0]   FRAME_MARK      = 8'hFF;
  localparam logic [POS_W-1:0]    POS_IDLE        = 4'd0;
  localparam logic [POS_W-1:0]    POS_LEVEL_HIGH  = 4'd4;
  localparam logic [POS_W-1:0]    POS_LEVEL_LOW   = 4'd5;
  localparam logic [POS_W-1:0]    POS_CHECKSUM    = 4'd8;
  localparam logic [CONC_W-1:0]   LEVEL_CLAMP     = 13'd5000;
  localparam logic [SCALED_W-1:0] THRESHOLD_RESET = 15'd320;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    CFG_ALARM_ENABLE = 1'b0,
    CFG_TRIP_LEVEL   = 1'b1
  } cfg_index_t;

  // One completed frame, as captured by the tracker.
  typedef struct packed {
    logic              checksum_ok;
    logic [BYTE_W-1:0] level_high;
    logic [BYTE_W-1:0] level_low;
  } frame_rec_t;

  // One result item.
  typedef struct packed {
    logic                checksum_ok;
    logic [CONC_W-1:0]   concentration;
    logic [SCALED_W-1:0] scaled_level;
    logic                over_threshold;
    logic                alarm_rising;
  } result_t;

endpackage

>>> hdl/gsfp_frame_tracker.sv
// ----------------------------------------------------------------------------
// Gas sensor frame tracker
// Follows the byte position inside a frame, accumulates the checksum and
// captures the level bytes; registers one record per completed frame.
// ----------------------------------------------------------------------------
module gsfp_frame_tracker (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  accept,
  input  logic [7:0]            rx_byte,
  input  logic                  advance,
  output logic                  rec_valid,
  output gsfp_pkg::frame_rec_t  rec
);
  import gsfp_pkg::*;

  logic [POS_W-1:0]  frame_position;
  logic [BYTE_W-1:0] checksum_sum;
  logic [BYTE_W-1:0] level_high_byte;
  logic [BYTE_W-1:0] level_low_byte;
  logic [BYTE_W-1:0] sum_next;

  assign sum_next = checksum_sum + rx_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_position  <= POS_IDLE;
      checksum_sum    <= '0;
      level_high_byte <= '0;
      level_low_byte  <= '0;
      rec_valid       <= 1'b0;
    end else begin
      // A new record may land in the same cycle the old one moves on.
      if (accept && (frame_position == POS_CHECKSUM)) begin
        rec_valid <= 1'b1;
      end else if (advance) begin
        rec_valid <= 1'b0;
      end
      if (accept) begin
        if (frame_position == POS_IDLE) begin
          if (rx_byte == FRAME_MARK) begin
            frame_position <= POS_IDLE + 4'd1;
            checksum_sum   <= '0;
          end
        end else if (frame_position == POS_CHECKSUM) begin
          // The checksum byte plus the running sum is zero on a good frame.
          frame_position  <= POS_IDLE;
          rec.checksum_ok <= (sum_next == '0);
          rec.level_high  <= level_high_byte;
          rec.level_low   <= level_low_byte;
        end else begin
          checksum_sum   <= sum_next;
          frame_position <= frame_position + 4'd1;
          if (frame_position == POS_LEVEL_HIGH) begin
            level_high_byte <= rx_byte;
          end
          if (frame_position == POS_LEVEL_LOW) begin
            level_low_byte <= rx_byte;
          end
        end
      end
    end
  end

endmodule

>>> hdl/gsfp_level_eval.sv
// ----------------------------------------------------------------------------
// Gas sensor level evaluation
// Clamps and scales the concentration of a completed frame, evaluates the
// alarm and its rising edge, and holds the result in the output register.
// ----------------------------------------------------------------------------
module gsfp_level_eval (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  rec_valid,
  input  gsfp_pkg::frame_rec_t  rec,
  input  logic                  alarm_enable,
  input  logic [14:0]           trip_level,
  input  logic                  out_stall,
  output logic                  advance,
  output logic                  out_valid,
  output gsfp_pkg::result_t     result
);
  import gsfp_pkg::*;

  logic                  alarm_latched;
  logic [15:0]           level_raw;
  logic [CONC_W-1:0]     level_clamped;
  logic [SCALED_W-1:0]   level_scaled;
  logic                  over_now;
  result_t               result_next;

  assign advance   = rec_valid && (!out_valid || !out_stall);
  assign level_raw = {rec.level_high, rec.level_low};

  always_comb begin
    if (level_raw > {3'b000, LEVEL_CLAMP}) begin
      level_clamped = LEVEL_CLAMP;
    end else begin
      level_clamped = level_raw[CONC_W-1:0];
    end
    // Times five as four plus one.
    level_scaled = {2'b00, level_clamped} + {level_clamped, 2'b00};
    over_now     = alarm_enable && (level_scaled > trip_level);

    result_next = '0;
    result_next.checksum_ok = rec.checksum_ok;
    if (rec.checksum_ok) begin
      result_next.concentration  = level_clamped;
      result_next.scaled_level   = level_scaled;
      result_next.over_threshold = over_now;
      result_next.alarm_rising   = over_now && !alarm_latched;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid     <= 1'b0;
      alarm_latched <= 1'b0;
    end else begin
      if (advance) begin
        out_valid <= 1'b1;
        if (rec.checksum_ok) begin
          alarm_latched <= over_now;
        end
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= result_next;
    end
  end

endmodule

>>> hdl/gas_sensor_frame_parser.sv
// ----------------------------------------------------------------------------
// Gas sensor frame parser
// Parses nine-byte sensor frames from a serial byte stream, checks the
// checksum, and reports clamped and scaled concentration with an alarm flag.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle, sustained; the byte path never waits on
//   arithmetic, only on a full output register.
// Result path: the edge that accepts the checksum byte loads the frame record
//   register, and the output register loads from it once it is empty or its
//   result is being taken.
// Reset: rst is synchronous and active high; it returns the parser to idle,
//   empties both registers, clears the alarm latch, disables the alarm and
//   sets the threshold to 320.
// ----------------------------------------------------------------------------
module gas_sensor_frame_parser (
  input  logic        clk,
  input  logic        rst,
  // Configuration write port.
  input  logic        cfg_write_enable,
  input  logic [0:0]  cfg_index,
  input  logic [14:0] cfg_data,
  // Received byte channel.
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  // Result channel.
  output logic        out_valid,
  input  logic        out_stall,
  output logic        checksum_ok,
  output logic [12:0] concentration,
  output logic [14:0] scaled_level,
  output logic        over_threshold,
  output logic        alarm_rising
);
  import gsfp_pkg::*;

  // Configuration registers. The index is one bit wide, so every code names
  // one of the two registers.
  logic                alarm_enable;
  logic [SCALED_W-1:0] trip_level;

  always_ff @(posedge clk) begin
    if (rst) begin
      alarm_enable <= 1'b0;
      trip_level   <= THRESHOLD_RESET;
    end else if (cfg_write_enable) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_ALARM_ENABLE: alarm_enable <= cfg_data[0];
        CFG_TRIP_LEVEL:   trip_level   <= cfg_data;
        default: ;
      endcase
    end
  end

  // The tracker holds at most one completed frame. Bytes are only refused
  // while that record is waiting and the output register cannot take it.
  // Because frames are nine bytes long this happens only under a long stall
  // on the result side.
  logic       rec_valid;
  frame_rec_t rec;
  logic       advance;
  logic       in_accept;
  result_t    result;

  assign in_stall  = rec_valid && !advance;
  assign in_accept = in_valid && !in_stall;

  gsfp_frame_tracker u_tracker (
    .clk       (clk),
    .rst       (rst),
    .accept    (in_accept),
    .rx_byte   (rx_byte),
    .advance   (advance),
    .rec_valid (rec_valid),
    .rec       (rec)
  );

  // The alarm latch lives in the evaluation stage. Consecutive frames are at
  // least nine bytes apart, so the latch is always settled before the next
  // frame reaches it.
  gsfp_level_eval u_eval (
    .clk          (clk),
    .rst          (rst),
    .rec_valid    (rec_valid),
    .rec          (rec),
    .alarm_enable (alarm_enable),
    .trip_level   (trip_level),
    .out_stall    (out_stall),
    .advance      (advance),
    .out_valid    (out_valid),
    .result       (result)
  );

  assign checksum_ok    = result.checksum_ok;
  assign concentration  = result.concentration;
  assign scaled_level   = result.scaled_level;
  assign over_threshold = result.over_threshold;
  assign alarm_rising   = result.alarm_rising;

endmodule

>>> hdl/gsfp_checker.sv
// ----------------------------------------------------------------------------
// Gas sensor frame parser checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module gsfp_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic        checksum_ok,
  input logic [12:0] concentration,
  input logic [14:0] scaled_level,
  input logic        over_threshold,
  input logic        alarm_rising
);
  import gsfp_pkg::*;

  // A stalled result stays valid and keeps its checksum flag, concentration and scaled level.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(concentration)
      && $stable(scaled_level) && $stable(checksum_ok))
    else $error("result changed while stalled");

  // A frame with a bad checksum reports nothing else.
  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !checksum_ok |-> concentration == '0 && scaled_level == '0
      && !over_threshold && !alarm_rising)
    else $error("bad checksum result carries data");

  // The concentration stays within the clamp, and the scaled level is five times it.
  a_scale: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> concentration <= LEVEL_CLAMP
      && scaled_level == ({2'b00, concentration} + {concentration, 2'b00}))
    else $error("concentration clamp or scale mismatch");

  // A rising alarm is always an alarm.
  a_rise: assert property (@(posedge clk) disable iff (rst)
    out_valid && alarm_rising |-> over_threshold)
    else $error("alarm rising without alarm");

endmodule

bind gas_sensor_frame_parser gsfp_checker u_gsfp_checker (.*);

>>> tb/gas_sensor_frame_parser_test.sv
// ----------------------------------------------------------------------------
// Gas sensor frame parser testbench
// Drives received bytes into the frame parser under several alarm settings and
// handshake pressure levels. A behavioral predictor tracks the frame position,
// running checksum and alarm latch. Every result item is compared field by
// field with the oldest expected result.
// ----------------------------------------------------------------------------
module gas_sensor_frame_parser_test;
  timeunit 1ns;
  timeprecision 1ps;

  import gsfp_pkg::*;

  // The concentration is scaled by 5 to give units of 1/4000 mg per cubic metre.
  localparam int unsigned LEVEL_GAIN     = 5;
  // Two register stages sit behind the checksum byte, so waiting SETTLE_CYCLES is
  // enough for anything still in flight to show up.
  localparam int unsigned SETTLE_CYCLES  = 6;
  localparam int unsigned HOLDOFF_CYCLES = 300;
  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned PHASE_BYTES    = 210;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_write_enable;
  cfg_index_t  cfg_index;
  logic [14:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  rx_byte;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        checksum_ok;
  logic [12:0] concentration;
  logic [14:0] scaled_level;
  logic        over_threshold;
  logic        alarm_rising;

  gas_sensor_frame_parser uut (
    .clk              (clk),
    .rst              (rst),
    .cfg_write_enable (cfg_write_enable),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .rx_byte          (rx_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .checksum_ok      (checksum_ok),
    .concentration    (concentration),
    .scaled_level     (scaled_level),
    .over_threshold   (over_threshold),
    .alarm_rising     (alarm_rising)
  );

  always #4 clk = ~clk;

  // Mirror of the alarm registers, kept in step with every register write.
  logic        alarm_on    = 1'b0;
  logic [14:0] alarm_limit = THRESHOLD_RESET;

  // Parser state as the predictor sees it.
  logic [3:0]  frame_pos  = POS_IDLE;
  logic [7:0]  byte_sum   = 8'd0;
  logic [7:0]  level_hi   = 8'd0;
  logic [7:0]  level_lo   = 8'd0;
  logic        alarm_seen = 1'b0;

  // Results that frames already accepted must still produce, oldest first.
  result_t     pending_frames[$];

  int unsigned failures       = 0;
  int unsigned sender_idle    = 0;  // percent of cycles the sender holds off
  int unsigned receiver_stall = 0;  // percent of cycles the receiver stalls
  int unsigned holdoff_asked  = 0;  // long receiver hold-offs requested so far
  int unsigned holdoff_served = 0;  // and the number already started
  int unsigned holdoff_left   = 0;
  int unsigned stuck_cycles   = 0;

  // One row of the directed stimulus. Where typed is set the row closes a frame
  // whose result is easy to read off by hand, and that result is expected as is.
  typedef struct packed {
    logic [7:0] rx;
    logic       typed;
    result_t    want;
  } byte_row_t;

  localparam result_t CLAMPED_OK = '{checksum_ok: 1'b1, concentration: LEVEL_CLAMP,
                                     scaled_level: 15'd25000, over_threshold: 1'b0,
                                     alarm_rising: 1'b0};
  localparam result_t BAD_SUM    = '0;

  localparam int unsigned DIRECTED_ROWS = 28;
  localparam byte_row_t DIRECTED [DIRECTED_ROWS] = '{
    // A stray zero byte while idle is ignored.
    '{8'h00, 1'b0, BAD_SUM},
    // Concentration exactly at the clamp, all other data bytes zero. The alarm
    // is still disabled after reset, so it stays quiet.
    '{8'hFF, 1'b0, BAD_SUM}, '{8'h00, 1'b0, BAD_SUM}, '{8'h00, 1'b0, BAD_SUM},
    '{8'h00, 1'b0, BAD_SUM}, '{8'h13, 1'b0, BAD_SUM}, '{8'h88, 1'b0, BAD_SUM},
    '{8'h00, 1'b0, BAD_SUM}, '{8'h00, 1'b0, BAD_SUM}, '{8'h65, 1'b1, CLAMPED_OK},
    // Marker bytes inside a frame are plain data; 0xFFFF clamps to 5000.
    '{8'hFF, 1'b0, BAD_SUM}, '{8'hFF, 1'b0, BAD_SUM}, '{8'hFF, 1'b0, BAD_SUM},
    '{8'hFF, 1'b0, BAD_SUM}, '{8'hFF, 1'b0, BAD_SUM}, '{8'hFF, 1'b0, BAD_SUM},
    '{8'hFF, 1'b0, BAD_SUM}, '{8'hFF, 1'b0, BAD_SUM}, '{8'h07, 1'b1, CLAMPED_OK},
    // A wrong checksum zeroes every field of the result.
    '{8'hFF, 1'b0, BAD_SUM}, '{8'h01, 1'b0, BAD_SUM}, '{8'h02, 1'b0, BAD_SUM},
    '{8'h03, 1'b0, BAD_SUM}, '{8'h04, 1'b0, BAD_SUM}, '{8'h05, 1'b0, BAD_SUM},
    '{8'h06, 1'b0, BAD_SUM}, '{8'h07, 1'b0, BAD_SUM}, '{8'h00, 1'b1, BAD_SUM}
  };

  // Advances the predicted parser by one received byte. Returns 1 when the byte
  // completes a frame, with the frame's result in res.
  function automatic bit parse_rx_byte(input logic [7:0] b, output result_t res);
    logic [15:0] raw_level;
    logic [7:0]  sum_needed;
    res = '0;
    if (frame_pos == POS_IDLE) begin
      if (b == FRAME_MARK) begin
        frame_pos = 4'd1;
        byte_sum  = 8'd0;
      end
      return 1'b0;
    end
    if (frame_pos < POS_CHECKSUM) begin
      byte_sum = byte_sum + b;
      if (frame_pos == POS_LEVEL_HIGH) begin
        level_hi = b;
      end else if (frame_pos == POS_LEVEL_LOW) begin
        level_lo = b;
      end
      frame_pos = frame_pos + 4'd1;
      return 1'b0;
    end
    frame_pos  = POS_IDLE;
    sum_needed = 8'd0 - byte_sum;
    if (b == sum_needed) begin
      raw_level           = {level_hi, level_lo};
      res.checksum_ok     = 1'b1;
      res.concentration   = (raw_level > LEVEL_CLAMP) ? LEVEL_CLAMP : raw_level[12:0];
      res.scaled_level    = 15'(res.concentration * LEVEL_GAIN);
      res.over_threshold  = alarm_on && (res.scaled_level > alarm_limit);
      res.alarm_rising    = res.over_threshold && !alarm_seen;
      alarm_seen          = res.over_threshold;
    end
    return 1'b1;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      failures++;
    end
  endfunction

  // Offers one item after a random number of idle cycles and returns at the
  // clock edge that accepts it. The stall is looked at on the falling edge,
  // where it has settled to the value the next rising edge will see.
  task automatic send_byte(input logic [7:0] b, input logic typed, input result_t want);
    result_t predicted;
    while ($urandom_range(99) < sender_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    do @(negedge clk); while (in_stall);
    @(posedge clk);
    if (parse_rx_byte(b, predicted)) begin
      pending_frames.push_back(typed ? want : predicted);
    end
  endtask

  // The sender pauses here until every frame already sent has reported back,
  // and then a little longer so that nothing is left in the pipeline.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_frames.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Both registers are written on back to back cycles, only with the parser
  // empty, so the new setting applies cleanly to the next frame to complete.
  task automatic set_alarm(input logic enable, input logic [14:0] threshold);
    drain_results();
    cfg_write_enable <= 1'b1;
    cfg_index        <= CFG_ALARM_ENABLE;
    cfg_data         <= {14'd0, enable};
    @(posedge clk);
    cfg_index        <= CFG_TRIP_LEVEL;
    cfg_data         <= threshold;
    @(posedge clk);
    cfg_write_enable <= 1'b0;
    alarm_on    = enable;
    alarm_limit = threshold;
  endtask

  // Random traffic: mostly well formed frames with random content, separated by
  // noise, with some frames cut short and some carrying a wrong checksum.
  // Full frames count nine bytes toward the budget and cut frames four; noise bytes do not.
  task automatic send_traffic(input int unsigned budget);
    int unsigned sent;
    int unsigned pick;
    int unsigned near;
    logic [7:0]  body [1:7];
    logic [7:0]  sum;
    logic [15:0] level;
    sent = 0;
    while (sent < budget) begin
      repeat ($urandom_range(0, 3)) send_byte(8'($urandom_range(0, 254)), 1'b0, '0);
      pick = $urandom_range(99);
      if (pick < 8) begin
        // A frame that stops early; whatever follows is taken as its tail.
        send_byte(FRAME_MARK, 1'b0, '0);
        repeat ($urandom_range(1, 7)) send_byte(8'($urandom), 1'b0, '0);
        sent += 4;
      end else begin
        case ($urandom_range(3))
          0: level = 16'($urandom);
          1: level = 16'($urandom_range(0, 5000));
          2: begin
            // Straddle the threshold so the alarm flips back and forth.
            near  = alarm_limit / LEVEL_GAIN;
            level = 16'(near + $urandom_range(0, 2));
            if (level != 16'd0) level = level - 16'd1;
          end
          default: begin
            case ($urandom_range(3))
              0: level = 16'd0;
              1: level = 16'd5000;
              2: level = 16'd5001;
              default: level = 16'hFFFF;
            endcase
          end
        endcase
        sum = 8'd0;
        for (int i = 1; i <= 7; i++) begin
          body[i] = 8'($urandom);
          if (i == 4) body[i] = level[15:8];
          if (i == 5) body[i] = level[7:0];
          sum = sum + body[i];
        end
        sum = 8'd0 - sum;
        if ($urandom_range(9) == 0) sum = sum + 8'($urandom_range(1, 255));
        send_byte(FRAME_MARK, 1'b0, '0);
        for (int i = 1; i <= 7; i++) send_byte(body[i], 1'b0, '0);
        send_byte(sum, 1'b0, '0);
        sent += 9;
      end
    end
  endtask

  task automatic run_phase(input logic enable, input logic [14:0] threshold,
                           input int unsigned idle_pct, input int unsigned stall_pct,
                           input logic long_holdoff);
    set_alarm(enable, threshold);
    sender_idle    = idle_pct;
    receiver_stall = stall_pct;
    // The receiver goes quiet for a long stretch while the sender keeps going,
    // so the output fills up and the parser has to stall its input.
    if (long_holdoff) holdoff_asked++;
    send_traffic(PHASE_BYTES);
  endtask

  // Receiver: random stalls at the current rate, or a long hold-off on request.
  always @(posedge clk) begin
    if (holdoff_left != 0) begin
      out_stall    <= 1'b1;
      holdoff_left <= holdoff_left - 1;
    end else if (holdoff_served != holdoff_asked) begin
      out_stall      <= 1'b1;
      holdoff_served <= holdoff_served + 1;
      holdoff_left   <= HOLDOFF_CYCLES;
    end else begin
      out_stall <= ($urandom_range(99) < receiver_stall);
    end
  end

  // Result check. A result item seen valid and unstalled on the falling edge is
  // taken at the next rising edge, and its fields are stable until then.
  always @(negedge clk) begin : result_check
    result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_frames.size() == 0) begin
        $error("result item arrived with no frame outstanding");
        failures++;
      end else begin
        want = pending_frames.pop_front();
        check_field("checksum_ok", 32'(want.checksum_ok), 32'(checksum_ok));
        check_field("concentration", 32'(want.concentration), 32'(concentration));
        check_field("scaled_level", 32'(want.scaled_level), 32'(scaled_level));
        check_field("over_threshold", 32'(want.over_threshold), 32'(over_threshold));
        check_field("alarm_rising", 32'(want.alarm_rising), 32'(alarm_rising));
      end
    end
  end

  // Watchdog: counts cycles in which neither channel moves an item.
  always @(negedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    rst              = 1'b1;
    cfg_write_enable = 1'b0;
    cfg_index        = CFG_ALARM_ENABLE;
    cfg_data         = 15'd0;
    in_valid         = 1'b0;
    rx_byte          = 8'd0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed rows run with the register values left by reset.
    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      send_byte(DIRECTED[i].rx, DIRECTED[i].typed, DIRECTED[i].want);
    end

    // Random phases: alarm settings from the lowest to the highest threshold, each
    // paired with one of the idling patterns of the two channels.
    run_phase(1'b1, 15'd0,                         0,  0,  1'b1);
    run_phase(1'b1, THRESHOLD_RESET,               54, 0,  1'b0);
    run_phase(1'b0, 15'd25000,                     0,  54, 1'b0);
    run_phase(1'b1, 15'd25000,                     8,  8,  1'b0);
    run_phase(1'b1, 15'h7FFF,                      0,  0,  1'b0);
    run_phase(1'b1, 15'($urandom_range(0, 25000)), 54, 0,  1'b0);
    run_phase(1'b1, 15'd24999,                     0,  54, 1'b0);
    run_phase(1'b1, 15'($urandom_range(0, 25000)), 8,  8,  1'b0);

    drain_results();
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
